// ----- rtl/ps2_mouse_packet_tracker_core_macros.svh -----
// ----------------------------------------------------------------------------
// PS/2 mouse packet tracker assertion macros
// Clocked assertion helpers shared by the tracker RTL.
// ----------------------------------------------------------------------------
`ifndef PS2_MOUSE_PACKET_TRACKER_CORE_MACROS_SVH
`define PS2_MOUSE_PACKET_TRACKER_CORE_MACROS_SVH

// Checks a property on every rising edge of clk_i outside of reset.
`define PS2MPT_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Checks that post holds in the cycle after pre.
`define PS2MPT_ASSERT_NEXT(lbl, pre, post, msg) \
  `PS2MPT_ASSERT(lbl, (pre) |=> (post), msg)

`endif

// ----- rtl/ps2mpt_pkg.sv -----
// ----------------------------------------------------------------------------
// PS/2 mouse packet tracker package
// Beat types, register indexes and widths shared by the tracker modules.
// ----------------------------------------------------------------------------
package ps2mpt_pkg;

  // Width of the position accumulators.
  localparam int unsigned POS_WIDTH = 16;
  // Width of the position fields on the result beat and of the limits.
  localparam int unsigned OUT_W     = 16;
  localparam int unsigned LIMIT_W   = 16;
  // Signed movement width: 9-bit movement shifted left by up to seven.
  localparam int unsigned MOVE_W    = 17;
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned CFG_DATA_W = 16;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_WHEEL_MODE  = 3'd0,
    CFG_SPEED_SHIFT = 3'd1,
    CFG_X_LIMIT     = 3'd2,
    CFG_Y_LIMIT     = 3'd3,
    CFG_Z_LIMIT     = 3'd4
  } ps2mpt_cfg_idx_e;

  typedef struct packed {
    logic [7:0] status_byte;
    logic [7:0] x_byte;
    logic [7:0] y_byte;
    logic [7:0] extra_byte;
  } ps2mpt_in_t;

  typedef struct packed {
    logic [4:0]       button_bits;
    logic [OUT_W-1:0] x_position;
    logic [OUT_W-1:0] y_position;
    logic [OUT_W-1:0] z_position;
  } ps2mpt_out_t;

  // Raw movement fields of one axis as carried by the packet.
  typedef struct packed {
    logic [7:0] low;
    logic       sign;
    logic       ovf;
  } ps2mpt_axis_t;

endpackage

// ----- rtl/ps2mpt_move.sv -----
// ----------------------------------------------------------------------------
// PS/2 mouse axis movement decoder
// Builds the signed 9-bit movement of one axis and applies the speed shift.
// ----------------------------------------------------------------------------
module ps2mpt_move import ps2mpt_pkg::*; (
  input  ps2mpt_axis_t             axis_i,
  input  logic signed [3:0]        shift_i,
  output logic signed [MOVE_W-1:0] move_o
);

  logic signed [MOVE_W-1:0] raw;
  logic [3:0]               rshift;

  assign raw    = {{(MOVE_W-8){axis_i.sign}}, axis_i.low};
  // Magnitude of a negative shift; minus eight maps to eight.
  assign rshift = ~shift_i + 4'd1;

  always_comb begin
    if (axis_i.ovf) begin
      move_o = axis_i.sign ? -MOVE_W'(255) : MOVE_W'(255);
    end else if (shift_i[3]) begin
      move_o = raw >>> rshift;
    end else begin
      move_o = raw <<< shift_i[2:0];
    end
  end

endmodule

// ----- rtl/ps2mpt_clamp.sv -----
// ----------------------------------------------------------------------------
// PS/2 mouse position add and clamp
// Adds a signed movement to a position and clamps it to zero and the limit.
// ----------------------------------------------------------------------------
module ps2mpt_clamp import ps2mpt_pkg::*; (
  input  logic [POS_WIDTH-1:0]     pos_i,
  input  logic signed [MOVE_W-1:0] move_i,
  input  logic [LIMIT_W-1:0]       limit_i,
  output logic [POS_WIDTH-1:0]     pos_o
);

  localparam int unsigned WIDE_W = (POS_WIDTH > MOVE_W) ? POS_WIDTH : MOVE_W;
  localparam int unsigned SUM_W  = ((WIDE_W > LIMIT_W) ? WIDE_W : LIMIT_W) + 2;
  localparam logic [POS_WIDTH-1:0] POS_MAX = '1;

  logic signed [SUM_W-1:0] sum;
  logic signed [SUM_W-1:0] lim_s;
  logic signed [SUM_W-1:0] max_s;
  logic signed [SUM_W-1:0] lim_eff;

  assign sum     = SUM_W'(pos_i) + SUM_W'(move_i);
  assign lim_s   = SUM_W'(limit_i);
  assign max_s   = SUM_W'(POS_MAX);
  // A limit beyond the accumulator range is cut to the largest position.
  assign lim_eff = (lim_s > max_s) ? max_s : lim_s;

  always_comb begin
    if (sum < 0) begin
      pos_o = '0;
    end else if (sum > lim_eff) begin
      pos_o = POS_WIDTH'(lim_eff);
    end else begin
      pos_o = POS_WIDTH'(sum);
    end
  end

endmodule

// ----- rtl/ps2_mouse_packet_tracker_core.sv -----
// ----------------------------------------------------------------------------
// PS/2 mouse packet tracker core
// Decodes whole mouse packets into buttons and clamped X, Y, wheel positions.
// ----------------------------------------------------------------------------
//  Channel  Handshake                Payload
//  in       in_valid_i / in_ready_o  in_data_i   (ps2mpt_in_t)
//  out      out_valid_o / out_ready_i out_data_o (ps2mpt_out_t)
//  cfg      cfg_we_i                 cfg_idx_i, cfg_wdata_i
//
// A packet beat is registered, then decoded and accumulated into the result
// register when that register can advance; one beat per cycle unless it stalls.
// The position accumulators form the only loop, closed through one register.
// A stalled result holds while one more packet waits in the input register.
// Reset clears the accumulators and loads the register defaults.
// ----------------------------------------------------------------------------
`include "ps2_mouse_packet_tracker_core_macros.svh"

module ps2_mouse_packet_tracker_core import ps2mpt_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  ps2mpt_in_t            in_data_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output ps2mpt_out_t           out_data_o,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i
);

  logic [1:0]         wheel_mode_q;
  logic signed [3:0]  speed_shift_q;
  logic [LIMIT_W-1:0] x_limit_q, y_limit_q, z_limit_q;

  ps2mpt_in_t           s1_q;
  logic                 s1_valid_q, s1_valid_d;
  ps2mpt_out_t          out_q, out_d;
  logic                 out_valid_q, out_valid_d;
  logic [POS_WIDTH-1:0] x_accum_q, y_accum_q, z_accum_q;
  logic [POS_WIDTH-1:0] x_accum_d, y_accum_d, z_accum_d;

  logic                     advance, s1_fire, in_fire;
  ps2mpt_axis_t             x_axis, y_axis;
  logic signed [MOVE_W-1:0] x_move, y_move, z_move;
  logic [POS_WIDTH-1:0]     x_next, y_next, z_next;
  logic [4:0]               buttons;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wheel_mode_q  <= 2'd0;
      speed_shift_q <= 4'sd0;
      x_limit_q     <= LIMIT_W'(1023);
      y_limit_q     <= LIMIT_W'(767);
      z_limit_q     <= LIMIT_W'(255);
    end else if (cfg_we_i) begin
      unique case (ps2mpt_cfg_idx_e'(cfg_idx_i))
        CFG_WHEEL_MODE:  wheel_mode_q  <= cfg_wdata_i[1:0];
        CFG_SPEED_SHIFT: speed_shift_q <= cfg_wdata_i[3:0];
        CFG_X_LIMIT:     x_limit_q     <= LIMIT_W'(cfg_wdata_i);
        CFG_Y_LIMIT:     y_limit_q     <= LIMIT_W'(cfg_wdata_i);
        CFG_Z_LIMIT:     z_limit_q     <= LIMIT_W'(cfg_wdata_i);
        default: ;
      endcase
    end
  end

  assign advance    = !out_valid_q || out_ready_i;
  assign s1_fire    = s1_valid_q && advance;
  assign in_ready_o = !s1_valid_q || advance;
  assign in_fire    = in_valid_i && in_ready_o;

  // Packet decode on the registered beat.
  assign x_axis = '{low: s1_q.x_byte, sign: s1_q.status_byte[4], ovf: s1_q.status_byte[6]};
  assign y_axis = '{low: s1_q.y_byte, sign: s1_q.status_byte[5], ovf: s1_q.status_byte[7]};

  ps2mpt_move u_x_move (.axis_i(x_axis), .shift_i(speed_shift_q), .move_o(x_move));
  ps2mpt_move u_y_move (.axis_i(y_axis), .shift_i(speed_shift_q), .move_o(y_move));

  always_comb begin
    buttons = {2'b00, s1_q.status_byte[2:0]};
    z_move  = '0;
    if (wheel_mode_q != 2'd0) begin
      z_move = {{(MOVE_W-4){s1_q.extra_byte[3]}}, s1_q.extra_byte[3:0]};
      if (wheel_mode_q[1]) begin
        buttons[4:3] = s1_q.extra_byte[5:4];
      end
    end
  end

  ps2mpt_clamp u_x_clamp (.pos_i(x_accum_q), .move_i(x_move), .limit_i(x_limit_q),
                          .pos_o(x_next));
  ps2mpt_clamp u_y_clamp (.pos_i(y_accum_q), .move_i(y_move), .limit_i(y_limit_q),
                          .pos_o(y_next));
  ps2mpt_clamp u_z_clamp (.pos_i(z_accum_q), .move_i(z_move), .limit_i(z_limit_q),
                          .pos_o(z_next));

  always_comb begin
    s1_valid_d  = in_fire ? 1'b1 : (s1_fire ? 1'b0 : s1_valid_q);
    out_valid_d = s1_fire ? 1'b1 : (out_ready_i ? 1'b0 : out_valid_q);
    x_accum_d   = x_accum_q;
    y_accum_d   = y_accum_q;
    z_accum_d   = z_accum_q;
    if (s1_fire) begin
      x_accum_d = x_next;
      y_accum_d = y_next;
      // The wheel position is left alone when the wheel did not move.
      if (z_move != '0) begin
        z_accum_d = z_next;
      end
    end
    out_d = '{button_bits: buttons,
              x_position:  OUT_W'(x_accum_d),
              y_position:  OUT_W'(y_accum_d),
              z_position:  OUT_W'(z_accum_d)};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      x_accum_q   <= '0;
      y_accum_q   <= '0;
      z_accum_q   <= '0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
      x_accum_q   <= x_accum_d;
      y_accum_q   <= y_accum_d;
      z_accum_q   <= z_accum_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_q <= in_data_i;
    end
    if (s1_fire) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  `PS2MPT_ASSERT_NEXT(a_fire_gives_result, s1_fire, out_valid_q,
                      "decoded packet did not reach the result register")
  `PS2MPT_ASSERT_NEXT(a_accum_hold, !s1_fire,
                      $stable(x_accum_q) && $stable(y_accum_q) && $stable(z_accum_q),
                      "accumulator changed without a packet")
  `PS2MPT_ASSERT_NEXT(a_three_button, s1_fire && !wheel_mode_q[1],
                      out_q.button_bits[4:3] == 2'b00,
                      "buttons four and five set outside five-button mode")
  `PS2MPT_ASSERT_NEXT(a_no_wheel, s1_fire && (wheel_mode_q == 2'd0), $stable(z_accum_q),
                      "wheel position moved with the wheel disabled")

endmodule

// ----- tb/ps2_mouse_packet_tracker_core_tb.sv -----
// ----------------------------------------------------------------------------
// PS/2 mouse packet tracker core testbench
// Sends whole mouse packets through the valid/ready input channel under random
// idling on both sides and a long receiver hold-off. An in-bench tracker
// predicts buttons and clamped X, Y and wheel positions for each packet. Each
// result beat is checked against the oldest prediction, field by field.
// ----------------------------------------------------------------------------
module ps2_mouse_packet_tracker_core_tb;
  import ps2mpt_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int unsigned HOLD_CYCLES = 80;
  localparam int unsigned RANDOM_PHASES = 7;
  localparam int unsigned PHASE_PACKETS = 100;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  ps2mpt_in_t            in_data = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  ps2mpt_out_t           out_data;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  // Tracker state and register copies used for prediction.
  logic [1:0]         wheel_mode_q;
  logic signed [3:0]  shift_q;
  logic [15:0]        lim_x, lim_y, lim_z;
  logic [15:0]        pos_x, pos_y, pos_z;

  ps2mpt_out_t predicted_reports[$];

  int unsigned cycles = 0;
  int unsigned mismatches = 0;
  int unsigned packets_sent = 0;
  int unsigned reports_checked = 0;
  int unsigned input_stalls = 0;
  int unsigned settings_used = 0;
  bit          tx_idle_on = 1'b0;
  bit          rx_idle_on = 1'b0;
  bit          rx_hold_req = 1'b0;

  ps2_mouse_packet_tracker_core uut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_data_o  (out_data),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_wdata_i (cfg_wdata)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("FAILED: results differ");
      $finish;
    end
  end

  // Mostly short gaps, now and then a long one.
  function automatic int unsigned pick_gap();
    if ($urandom_range(0, 9) == 0) return $urandom_range(8, 40);
    return $urandom_range(1, 3);
  endfunction

  function automatic int axis_move(logic [7:0] low, logic sign, logic ovf);
    int v;
    int sh;
    if (ovf) return sign ? -255 : 255;
    sh = int'(shift_q);
    v = int'(low) - (sign ? 256 : 0);
    if (sh > 0) v = v <<< sh;
    else if (sh < 0) v = v >>> (-sh);
    return v;
  endfunction

  function automatic logic [15:0] clamp_pos(logic [15:0] pos, int mov, logic [15:0] lim);
    int r;
    r = int'(pos) + mov;
    if (r < 0) r = 0;
    if (r > int'(lim)) r = int'(lim);
    return r[15:0];
  endfunction

  // Advances the tracker by one packet and returns the report it produces.
  function automatic ps2mpt_out_t track_packet(ps2mpt_in_t pkt);
    ps2mpt_out_t rep;
    logic [4:0]  btn;
    int          zmov;
    btn = {2'b00, pkt.status_byte[2:0]};
    zmov = 0;
    if (wheel_mode_q != 2'd0) begin
      zmov = int'(pkt.extra_byte[3:0]) - (pkt.extra_byte[3] ? 16 : 0);
      if (wheel_mode_q[1]) btn[4:3] = pkt.extra_byte[5:4];
    end
    pos_x = clamp_pos(pos_x, axis_move(pkt.x_byte, pkt.status_byte[4], pkt.status_byte[6]),
                      lim_x);
    pos_y = clamp_pos(pos_y, axis_move(pkt.y_byte, pkt.status_byte[5], pkt.status_byte[7]),
                      lim_y);
    // The wheel position is only touched when the wheel actually moved.
    if (zmov != 0) pos_z = clamp_pos(pos_z, zmov, lim_z);
    rep.button_bits = btn;
    rep.x_position = pos_x;
    rep.y_position = pos_y;
    rep.z_position = pos_z;
    return rep;
  endfunction

  function automatic ps2mpt_in_t rand_packet(int unsigned neg_pct);
    ps2mpt_in_t p;
    p.status_byte = 8'($urandom_range(0, 255));
    p.status_byte[4] = ($urandom_range(0, 99) < neg_pct);
    p.status_byte[5] = ($urandom_range(0, 99) < neg_pct);
    p.status_byte[6] = ($urandom_range(0, 15) == 0);
    p.status_byte[7] = ($urandom_range(0, 15) == 0);
    p.x_byte = 8'($urandom_range(0, 255));
    p.y_byte = 8'($urandom_range(0, 255));
    p.extra_byte = 8'($urandom_range(0, 255));
    // Small movements keep positions wandering rather than pinned.
    if ($urandom_range(0, 2) == 0) p.x_byte = p.status_byte[4] ? 8'hff - 8'($urandom_range(0, 7))
                                                               : 8'($urandom_range(0, 7));
    if ($urandom_range(0, 2) == 0) p.y_byte = p.status_byte[5] ? 8'hff - 8'($urandom_range(0, 7))
                                                               : 8'($urandom_range(0, 7));
    return p;
  endfunction

  // Called at a falling edge with the input channel idle.
  task automatic set_reg(ps2mpt_cfg_idx_e idx, logic [15:0] value);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_wdata <= value;
    case (idx)
      CFG_WHEEL_MODE:  wheel_mode_q = value[1:0];
      CFG_SPEED_SHIFT: shift_q = value[3:0];
      CFG_X_LIMIT:     lim_x = value;
      CFG_Y_LIMIT:     lim_y = value;
      CFG_Z_LIMIT:     lim_z = value;
      default: ;
    endcase
    @(negedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  task automatic set_all_regs(logic [1:0] wm, logic signed [3:0] sh,
                              logic [15:0] lx, logic [15:0] ly, logic [15:0] lz);
    set_reg(CFG_WHEEL_MODE, {14'd0, wm});
    set_reg(CFG_SPEED_SHIFT, {12'd0, sh});
    set_reg(CFG_X_LIMIT, lx);
    set_reg(CFG_Y_LIMIT, ly);
    set_reg(CFG_Z_LIMIT, lz);
    settings_used++;
  endtask

  // Called at a falling edge; returns at the falling edge after acceptance with
  // valid still high, so a following beat can go out back to back.
  task automatic send_packet(ps2mpt_in_t pkt);
    if (tx_idle_on && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat (pick_gap()) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data <= pkt;
    @(posedge clk);
    while (!in_ready) begin
      input_stalls++;
      @(posedge clk);
    end
    predicted_reports.push_back(track_packet(pkt));
    packets_sent++;
    @(negedge clk);
  endtask

  task automatic send_bytes(logic [7:0] st, logic [7:0] xb, logic [7:0] yb, logic [7:0] eb);
    send_packet({st, xb, yb, eb});
  endtask

  // Drops valid, waits for every report, then lets the pipeline settle.
  task automatic drain();
    in_valid <= 1'b0;
    while (predicted_reports.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  always @(posedge clk) begin : check_reports
    ps2mpt_out_t want;
    if (rst_n && out_valid && out_ready) begin
      reports_checked++;
      if (predicted_reports.size() == 0) begin
        $error("report beat with no packet pending: %p", out_data);
        mismatches++;
      end else begin
        want = predicted_reports.pop_front();
        if (out_data.button_bits !== want.button_bits) begin
          $error("button_bits: expected %0h, got %0h", want.button_bits, out_data.button_bits);
          mismatches++;
        end
        if (out_data.x_position !== want.x_position) begin
          $error("x_position: expected %0d, got %0d", want.x_position, out_data.x_position);
          mismatches++;
        end
        if (out_data.y_position !== want.y_position) begin
          $error("y_position: expected %0d, got %0d", want.y_position, out_data.y_position);
          mismatches++;
        end
        if (out_data.z_position !== want.z_position) begin
          $error("z_position: expected %0d, got %0d", want.z_position, out_data.z_position);
          mismatches++;
        end
      end
    end
  end

  // Result receiver: random stalls, plus one long hold-off on request.
  initial begin
    forever begin
      @(negedge clk);
      if (rx_hold_req) begin
        rx_hold_req = 1'b0;
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
      end else if (rx_idle_on && $urandom_range(0, 5) == 0) begin
        out_ready <= 1'b0;
        repeat (pick_gap()) @(negedge clk);
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  task automatic test_reset_defaults();
    // Registers hold their reset values here: wheel ignored, limits 1023/767/255.
    wheel_mode_q = 2'd0;
    shift_q = 4'sd0;
    lim_x = 16'd1023;
    lim_y = 16'd767;
    lim_z = 16'd255;
    pos_x = '0;
    pos_y = '0;
    pos_z = '0;
    send_bytes(8'h00, 8'h00, 8'h00, 8'hff);
    send_bytes(8'h07, 8'hff, 8'hff, 8'h3f);
    send_bytes(8'h30, 8'h00, 8'h00, 8'h00);
    send_bytes(8'h40, 8'h12, 8'h01, 8'h00);
    send_bytes(8'hb0, 8'h80, 8'h33, 8'h00);
    repeat (4) send_bytes(8'h4f, 8'hff, 8'hff, 8'h00);
    drain();
  endtask

  task automatic test_shift_extremes();
    // Shift of minus eight turns every X and Y movement without overflow into zero or minus one.
    set_all_regs(2'd3, -4'sd8, 16'd1023, 16'd767, 16'd255);
    send_bytes(8'h05, 8'hff, 8'h7f, 8'h37);
    send_bytes(8'h32, 8'hff, 8'h01, 8'h27);
    send_bytes(8'h00, 8'h00, 8'h00, 8'h18);
    send_bytes(8'hc0, 8'h00, 8'h00, 8'h07);
    drain();
    set_all_regs(2'd1, 4'sd7, 16'd0, 16'd65535, 16'd65535);
    send_bytes(8'h00, 8'h7f, 8'h7f, 8'h3f);
    send_bytes(8'h00, 8'hff, 8'hff, 8'h07);
    send_bytes(8'h30, 8'h01, 8'h00, 8'h08);
    drain();
  endtask

  task automatic test_lowered_limits();
    // Y and wheel positions sit above the new limits, X sits at zero: Y clamps even
    // without motion, the wheel stays put until it moves.
    set_all_regs(2'd2, 4'sd0, 16'd10, 16'd10, 16'd5);
    send_bytes(8'h00, 8'h00, 8'h00, 8'h30);
    send_bytes(8'h00, 8'h00, 8'h00, 8'h01);
    send_bytes(8'h30, 8'h00, 8'h00, 8'h0f);
    drain();
  endtask

  task automatic test_back_pressure();
    set_all_regs(2'd3, 4'sd1, 16'd2000, 16'd2000, 16'd100);
    tx_idle_on = 1'b0;
    rx_hold_req = 1'b1;
    repeat (24) send_packet(rand_packet(50));
    drain();
  endtask

  task automatic test_random_phases();
    logic [15:0]       lims[3];
    logic signed [3:0] sh;
    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      for (int a = 0; a < 3; a++) begin
        case ($urandom_range(0, 3))
          0: lims[a] = 16'd0;
          1: lims[a] = 16'($urandom_range(1, 300));
          2: lims[a] = 16'($urandom_range(0, 65535));
          default: lims[a] = 16'hffff;
        endcase
      end
      sh = 4'($urandom_range(0, 15));
      if (ph == 0) begin
        sh = -4'sd8;
        lims = '{16'hffff, 16'hffff, 16'hffff};
      end else if (ph == 1) begin
        sh = 4'sd7;
        lims = '{16'd0, 16'd0, 16'd0};
      end else if (ph == 2) begin
        sh = -4'sd7;
      end
      set_all_regs(2'($urandom_range(0, 3)), sh, lims[0], lims[1], lims[2]);
      // One phase runs flat out on both sides.
      tx_idle_on = (ph != 3);
      rx_idle_on = (ph != 3);
      begin
        int unsigned neg_pct;
        neg_pct = $urandom_range(20, 80);
        repeat (PHASE_PACKETS) send_packet(rand_packet(neg_pct));
      end
      drain();
    end
  endtask

  initial begin
    repeat (2) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);
    tx_idle_on = 1'b1;
    rx_idle_on = 1'b1;
    test_reset_defaults();
    test_shift_extremes();
    test_lowered_limits();
    test_back_pressure();
    test_random_phases();
    $display("Sent %0d packets over %0d register settings; %0d reports checked.",
             packets_sent, settings_used + 1, reports_checked);
    $display("Input was held back for %0d cycles while results were stalled.", input_stalls);
    if (mismatches == 0 && predicted_reports.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
